>>> rtl/core/edfls_pkg.sv
// shared types and constants for the edf latest start finder
package edfls_pkg;

  localparam int unsigned DATA_W       = 24;
  localparam int unsigned MAX_JOBS_DEF = 256;

  localparam logic [DATA_W-1:0] MAX_START_RST = DATA_W'(10000000);

  typedef struct packed {
    logic [DATA_W-1:0] dur;
    logic [DATA_W-1:0] dl;
  } job_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  // command to the slack accumulator
  typedef struct packed {
    logic step;
    logic clear;
  } acc_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

endpackage

>>> rtl/core/edfls_cell.sv
// one cell of the deadline-sorted job chain
module edfls_cell
  import edfls_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       held_i,
  input  job_t       new_job_i,
  input  job_t       prev_job_i,
  input  logic       prev_gt_i,
  input  job_t       next_job_i,
  output job_t       job_o,
  output logic       gt_o
);

  job_t job_q, job_d;

  // empty cells count as later than any deadline, so the chain stays monotone
  assign gt_o = !held_i || (job_q.dl > new_job_i.dl);

  always_comb begin
    job_d = job_q;
    if (ctrl_i.ins && gt_o) begin
      job_d = prev_gt_i ? prev_job_i : new_job_i;
    end else if (ctrl_i.shift) begin
      job_d = next_job_i;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_o = job_q;

endmodule

>>> rtl/core/edfls_chain.sv
// row of job cells: sorted insert and drain toward the head
module edfls_chain
  import edfls_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF,
  parameter int unsigned CNT_W    = $clog2(MAX_JOBS + 1)
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  job_t             new_job_i,
  output job_t             head_o
);

  job_t jobs [MAX_JOBS];
  logic gts  [MAX_JOBS];

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    job_t prev_job, next_job;
    logic prev_gt;
    logic held;

    assign held = CNT_W'(g) < count_i;

    if (g == 0) begin : g_first
      assign prev_job = new_job_i;
      assign prev_gt  = 1'b0;
    end else begin : g_inner
      assign prev_job = jobs[g-1];
      assign prev_gt  = gts[g-1];
    end

    if (g == MAX_JOBS - 1) begin : g_last
      assign next_job = new_job_i;
    end else begin : g_body
      assign next_job = jobs[g+1];
    end

    edfls_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .held_i     (held),
      .new_job_i  (new_job_i),
      .prev_job_i (prev_job),
      .prev_gt_i  (prev_gt),
      .next_job_i (next_job),
      .job_o      (jobs[g]),
      .gt_o       (gts[g])
    );
  end

  assign head_o = jobs[0];

endmodule

>>> rtl/core/edfls_slack.sv
// running duration sum and minimum slack over the drained jobs
module edfls_slack
  import edfls_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF,
  parameter int unsigned SUM_W    = DATA_W + $clog2(MAX_JOBS + 1),
  parameter int unsigned V_W      = SUM_W + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  acc_ctrl_t             ctrl_i,
  input  job_t                  head_i,
  output logic signed [V_W-1:0] best_o
);

  localparam logic signed [V_W-1:0] BestInit = {1'b0, {(V_W-1){1'b1}}};

  logic [SUM_W-1:0]      sum_q, sum_d;
  logic signed [V_W-1:0] best_q, best_d;
  logic signed [V_W-1:0] slack;

  assign slack = $signed({{(V_W-DATA_W){1'b0}}, head_i.dl})
               - $signed({1'b0, sum_q + SUM_W'(head_i.dur)});

  always_comb begin
    sum_d  = sum_q;
    best_d = best_q;
    if (ctrl_i.clear) begin
      sum_d  = '0;
      best_d = BestInit;
    end else if (ctrl_i.step) begin
      sum_d = sum_q + SUM_W'(head_i.dur);
      if (slack < best_q) begin
        best_d = slack;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      best_q <= BestInit;
    end else begin
      sum_q  <= sum_d;
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

>>> rtl/core/edf_latest_start_finder_top.sv
// top level: job intake, drain sequencer, result register and config
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_stall_o    | duration_i, deadline_i, last_job_i
//  out     | output    | out_valid_o / out_stall_i  | latest_start_o, infeasible_o, too_many_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_max_start_i
//
//  the cell chain inserts an accepted job beat in deadline order at once, or drops it when full
//  after a last_job beat the chain drains one job per cycle into the slack unit,
//  with in_stall_o high throughout the drain
//  the finishing step waits while a stalled result still sits in the output register
//  the result waits in an output register while the next set loads
//  reset empties the chain (count to zero) and sets max_start to 10000000
module edf_latest_start_finder_top
  import edfls_pkg::*;
#(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] duration_i,
  input  logic [DATA_W-1:0] deadline_i,
  input  logic              last_job_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] latest_start_o,
  output logic              infeasible_o,
  output logic              too_many_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DATA_W-1:0] cfg_max_start_i
);

  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned SUM_W = DATA_W + $clog2(MAX_JOBS + 1);
  localparam int unsigned V_W   = SUM_W + 1;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [DATA_W-1:0] max_start_q;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] start_q, start_d;
  logic              infeas_q, infeas_d;
  logic              many_q, many_d;

  logic       in_acc, full, head_held, finish;
  cell_ctrl_t cell_ctrl;
  acc_ctrl_t  acc_ctrl;
  job_t       new_job, head_job;

  logic signed [V_W-1:0] best, cap, capped;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign full        = (count_q == CNT_W'(MAX_JOBS));
  assign head_held   = (count_q != '0);
  assign cfg_ready_o = 1'b1;

  assign new_job.dur = duration_i;
  assign new_job.dl  = deadline_i;

  assign finish = (state_q == ST_DRAIN) && !head_held && (!out_valid_q || !out_stall_i);

  assign cell_ctrl.ins   = in_acc && !full;
  assign cell_ctrl.shift = (state_q == ST_DRAIN) && head_held;
  assign acc_ctrl.step   = cell_ctrl.shift;
  assign acc_ctrl.clear  = finish;

  edfls_chain #(
    .MAX_JOBS (MAX_JOBS),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (cell_ctrl),
    .count_i   (count_q),
    .new_job_i (new_job),
    .head_o    (head_job)
  );

  edfls_slack #(
    .MAX_JOBS (MAX_JOBS),
    .SUM_W    (SUM_W),
    .V_W      (V_W)
  ) u_slack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .head_i (head_job),
    .best_o (best)
  );

  assign cap    = $signed({{(V_W-DATA_W){1'b0}}, max_start_q});
  assign capped = (best > cap) ? cap : best;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    start_d     = start_q;
    infeas_d    = infeas_q;
    many_d      = many_q;

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (last_job_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (head_held) begin
          count_d = count_q - CNT_W'(1);
        end else if (finish) begin
          state_d     = ST_LOAD;
          ovf_d       = 1'b0;
          out_valid_d = 1'b1;
          if (ovf_q) begin
            start_d  = '0;
            infeas_d = 1'b1;
            many_d   = 1'b1;
          end else if (capped < $signed(V_W'(1))) begin
            start_d  = '0;
            infeas_d = 1'b1;
            many_d   = 1'b0;
          end else begin
            start_d  = capped[DATA_W-1:0];
            infeas_d = 1'b0;
            many_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      max_start_q <= MAX_START_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_start_q <= cfg_max_start_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    infeas_q <= infeas_d;
    many_q   <= many_d;
  end

  assign out_valid_o    = out_valid_q;
  assign latest_start_o = start_q;
  assign infeasible_o   = infeas_q;
  assign too_many_o     = many_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_JOBS))
    else $error("job count beyond store depth");

  a_result_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DRAIN))
    else $error("result appeared outside drain");

  a_infeas_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (infeas_q == (start_q == '0)))
    else $error("infeasible flag disagrees with start value");

  a_many_infeas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && many_q) |-> infeas_q)
    else $error("overflow result not flagged infeasible");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && full) |=> (ovf_q && count_q == CNT_W'(MAX_JOBS)))
    else $error("job beat on full store not dropped");

endmodule
